>>> src/fvf_pkg.sv
`timescale 1ns / 1ps

package fvf_pkg;

  // channel and field sizes
  localparam int CHANNELS   = 4;
  localparam int CH_W       = 2;
  localparam int GAIN_W     = 20;
  localparam int FULL_W     = 19;
  localparam int FRAMES_W   = 13;
  localparam int FRAMES_IN_W = 16;
  localparam int DIVISOR_W  = 12;
  localparam int DIVIDEND_W = 21;
  localparam int LEVEL_W    = 7;
  localparam int LEVEL_SHIFT = 12;
  localparam int CFG_IDX_W  = 3;

  // constants of the fade law
  localparam logic [FULL_W-1:0]   FULL_RESET = 19'h7F000;
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = 7'd127;
  localparam logic signed [FRAMES_IN_W-1:0] FRAMES_MAX = 16'sh0FFF;
  localparam logic signed [FRAMES_IN_W-1:0] FRAMES_MIN = -16'sh0FFF;

  // input kinds carried in tuser
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  typedef logic [GAIN_W-1:0]     gain_t;
  typedef logic [FULL_W-1:0]     full_t;
  typedef logic [LEVEL_W-1:0]    level_t;
  typedef logic [DIVIDEND_W-1:0] dividend_t;
  typedef logic [DIVISOR_W-1:0]  divisor_t;

  // handshake between sequencer and divider
  typedef struct packed {
    logic      start;
    dividend_t dividend;
    divisor_t  divisor;
  } div_req_t;

  typedef struct packed {
    logic      done;
    dividend_t quotient;
  } div_rsp_t;

endpackage

>>> src/fvf_div.sv
`timescale 1ns / 1ps

module fvf_div
  import fvf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_W - 1);

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0]    quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]     rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]     dvs_r, dvs_nxt;
  logic [DIVISOR_W:0]       rem_shift;
  logic [DIVISOR_W:0]       rem_sub;
  logic                     ge;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_shift = {rem_r, quo_r[DIVIDEND_W-1]};
  assign rem_sub   = rem_shift - {1'b0, dvs_r};
  assign ge        = (rem_shift >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIVIDEND_W-2:0], ge};
      rem_nxt = ge ? rem_sub[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

>>> src/four_channel_volume_fade.sv
`timescale 1ns / 1ps
// start transaction: loads the frame count, no result; tick with frames left:
// per channel a setup, 21 divider steps, done and write-back, then an emit of
// the registered result; idle tick goes straight to emit; emit waits on a stalled
// result; inputs are taken only in idle, and all channels use the single shared divider
// reset: synchronous active-low rst_n clears gains, frame count and output valid,
// full levels return to 0x7F000

module four_channel_volume_fade
  import fvf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [15:0]            in_tdata,   // [15:0] fade_frames
  input  logic [0:0]             in_tuser,   // [0] mode
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [31:0]            out_tdata,  // [6:0] mix_ll, [13:7] mix_lr,
                                             // [20:14] mix_rr, [27:21] mix_rl
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [FULL_W-1:0]      cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_POST = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

  logic [2:0]                 state_r, state_nxt;
  logic [CH_W-1:0]            ch_r, ch_nxt;
  logic signed [FRAMES_W-1:0] frames_r, frames_nxt;
  gain_t                      live_r [CHANNELS];
  gain_t                      live_nxt [CHANNELS];
  full_t                      full_r [CHANNELS];
  gain_t                      m_r, m_nxt;
  logic                       neg_r, neg_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [31:0]                out_data_r, out_data_nxt;

  div_req_t                   div_req;
  div_rsp_t                   div_rsp;

  logic                       in_fire;
  logic                       fade_in;
  divisor_t                   div_d;
  gain_t                      cur_gain;
  full_t                      cur_full;
  logic signed [GAIN_W:0]     diff;
  logic [GAIN_W:0]            abs_diff;
  gain_t                      m_sel;
  gain_t                      f_val;
  logic [GAIN_W:0]            q_val;
  logic [GAIN_W+1:0]          r_val;
  gain_t                      fade_in_gain;
  logic signed [FRAMES_IN_W-1:0] frames_in;
  logic [FRAMES_W-1:0]        frames_sat;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // frame count saturated to +-4095 on load
  assign frames_in = $signed(in_tdata);
  always_comb begin
    if (frames_in > FRAMES_MAX)
      frames_sat = FRAMES_W'(FRAMES_MAX);
    else if (frames_in < FRAMES_MIN)
      frames_sat = FRAMES_W'(FRAMES_MIN);
    else
      frames_sat = frames_in[FRAMES_W-1:0];
  end

  // direction and step divisor from the remaining frame count
  assign fade_in = frames_r[FRAMES_W-1];
  assign div_d   = fade_in ? DIVISOR_W'(-frames_r) : DIVISOR_W'(frames_r);

  // setup: magnitude to scale, gain itself or distance to full level
  assign cur_gain = live_r[ch_r];
  assign cur_full = full_r[ch_r];
  assign diff     = $signed({2'b00, cur_full}) - $signed({1'b0, cur_gain});
  assign abs_diff = diff[GAIN_W] ? $unsigned(-diff) : $unsigned(diff);
  assign m_sel    = fade_in ? abs_diff[GAIN_W-1:0] : cur_gain;

  // m*(d-1)/d floored equals m - ceil(m/d)
  assign f_val = m_r - div_rsp.quotient[GAIN_W-1:0];
  assign q_val = neg_r ? -{1'b0, f_val} : {1'b0, f_val};
  assign r_val = {3'b000, cur_full} - {q_val[GAIN_W], q_val};
  assign fade_in_gain = r_val[GAIN_W+1] ? '0 : r_val[GAIN_W-1:0];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    frames_nxt    = frames_r;
    m_nxt         = m_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_req.start    = 1'b0;
    div_req.dividend = {1'b0, m_sel} + {{(DIVIDEND_W-DIVISOR_W){1'b0}}, div_d} - 1'b1;
    div_req.divisor  = div_d;
    for (int i = 0; i < CHANNELS; i++) live_nxt[i] = live_r[i];

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser[0] == MODE_START) begin
            frames_nxt = $signed(frames_sat);
          end else if (frames_r == '0) begin
            state_nxt = ST_EMIT;
          end else begin
            ch_nxt    = '0;
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        m_nxt         = m_sel;
        neg_nxt       = fade_in && diff[GAIN_W];
        div_req.start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) state_nxt = ST_POST;
      end
      ST_POST: begin
        live_nxt[ch_r] = fade_in ? fade_in_gain : f_val;
        if (ch_r == CH_LAST) begin
          frames_nxt = fade_in ? frames_r + 1'b1 : frames_r - 1'b1;
          state_nxt  = ST_EMIT;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          for (int i = 0; i < CHANNELS; i++) begin
            out_data_nxt[i*LEVEL_W +: LEVEL_W] =
              live_r[i][GAIN_W-1] ? LEVEL_MAX : live_r[i][LEVEL_SHIFT +: LEVEL_W];
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and gain state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      frames_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        live_r[i] <= '0;
        full_r[i] <= FULL_RESET;
      end
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      frames_r    <= frames_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < CHANNELS; i++) live_r[i] <= live_nxt[i];
      if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(CHANNELS)))
        full_r[cfg_index[CH_W-1:0]] <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    m_r        <= m_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

  fvf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // divider answers only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("divider done outside wait state");

  // frame count stays within the saturated range
  assert property (@(posedge clk) disable iff (!rst_n)
    (frames_r <= $signed(FRAMES_W'(FRAMES_MAX))) &&
    (frames_r >= $signed(FRAMES_W'(FRAMES_MIN))))
    else $error("frame count out of range");

  // a start transaction returns to idle at once
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser[0] == MODE_START) |=> state_r == ST_IDLE)
    else $error("start transaction did not complete in one cycle");

  // last channel write-back always leads to the emit step
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POST && ch_r == CH_LAST) |=> state_r == ST_EMIT)
    else $error("tick did not reach emit after last channel");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import fvf_pkg::*;
();

  localparam int SETTLE_CYCLES = 150;
  localparam int PHASE_ITEMS   = 325;

  // full level register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FULL_LL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_LR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_RR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_RL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 3'd4;

  localparam full_t FULL_TOP = 19'd520192;

  // four mix levels, left-to-left in the lowest bits
  typedef logic [CHANNELS-1:0][LEVEL_W-1:0] mix_levels_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata   = '0;
  logic [0:0]           in_tuser   = MODE_TICK;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [FULL_W-1:0]    cfg_data   = '0;

  // shadow of the fade state
  full_t       fade_target [CHANNELS] = '{FULL_RESET, FULL_RESET, FULL_RESET, FULL_RESET};
  gain_t       fade_gain   [CHANNELS] = '{default: '0};
  int          frames_left = 0;

  mix_levels_t expected_mix [$];
  int unsigned mismatch_count = 0;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  string       lane_name [CHANNELS] = '{"ll", "lr", "rr", "rl"};

  always #10 clk = ~clk;

  four_channel_volume_fade u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // start transactions load the frame count; ticks take a fade step while frames are left and queue expected levels
  function automatic void predict_fade(input logic mode, input logic signed [15:0] frames);
    longint      diff;
    longint      quot;
    longint      res;
    int          k;
    mix_levels_t lv;
    if (mode == MODE_START) begin
      k = frames;
      if (k > FRAMES_MAX) k = FRAMES_MAX;
      if (k < FRAMES_MIN) k = FRAMES_MIN;
      frames_left = k;
      return;
    end
    if (frames_left > 0) begin
      for (int c = 0; c < CHANNELS; c++)
        fade_gain[c] = gain_t'((longint'(fade_gain[c]) * (frames_left - 1)) / frames_left);
      frames_left -= 1;
    end else if (frames_left < 0) begin
      k = -frames_left;
      for (int c = 0; c < CHANNELS; c++) begin
        // signed difference, quotient truncates toward zero
        diff = longint'(fade_target[c]) - longint'(fade_gain[c]);
        quot = (diff * (k - 1)) / k;
        res  = longint'(fade_target[c]) - quot;
        if (res < 0) res = 0;
        fade_gain[c] = gain_t'(res);
      end
      frames_left += 1;
    end
    for (int c = 0; c < CHANNELS; c++) begin
      if ((fade_gain[c] >> LEVEL_SHIFT) > LEVEL_MAX) lv[c] = LEVEL_MAX;
      else lv[c] = level_t'(fade_gain[c] >> LEVEL_SHIFT);
    end
    expected_mix.push_back(lv);
  endfunction

  // result side: random stalls and field compare against the oldest expectation
  always @(posedge clk) begin
    mix_levels_t want;
    mix_levels_t got;
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[CHANNELS*LEVEL_W-1:0];
      if (expected_mix.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result transaction: expected none, actual %h",
                 $time, got);
      end else begin
        want = expected_mix.pop_front();
        for (int c = 0; c < CHANNELS; c++) begin
          if (got[c] !== want[c]) begin
            mismatch_count++;
            $display("%0t mismatch mix_%s: expected %0d, actual %0d",
                     $time, lane_name[c], want[c], got[c]);
          end
        end
      end
    end
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(input logic mode, input logic signed [15:0] frames);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= frames;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_fade(mode, frames);
  endtask

  task automatic send_tick();
    send_item(MODE_TICK, 16'($urandom));
  endtask

  // let all results drain and the last start finish
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_mix.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input full_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx < REG_COUNT) fade_target[idx] = value;
    @(posedge clk);
  endtask

  task automatic set_targets(input full_t ll, input full_t lr, input full_t rr,
                             input full_t rl);
    write_reg(REG_FULL_LL, ll);
    write_reg(REG_FULL_LR, lr);
    write_reg(REG_FULL_RR, rr);
    write_reg(REG_FULL_RL, rl);
    // indexes past the last register must be ignored
    write_reg(REG_COUNT + CFG_IDX_W'($urandom_range(3)), full_t'($urandom));
  endtask

  // idle ticks, single-step fades, saturation of the frame count, restarts
  task automatic test_directed_ramps();
    send_gap_pct   = 30;
    recv_stall_pct = 30;
    send_tick();
    send_item(MODE_START, -16'sd1);
    send_tick();
    send_tick();
    send_item(MODE_START, 16'sh7FFF);
    send_tick();
    send_tick();
    send_item(MODE_START, 16'sd1);
    send_tick();
    send_item(MODE_START, 16'sh8000);
    send_tick();
    send_tick();
    send_item(MODE_START, 16'sd0);
    send_tick();
    send_item(MODE_START, -16'sd3);
    send_tick();
    send_tick();
    send_tick();
    send_tick();
    send_item(MODE_START, 16'sd3);
    send_item(MODE_START, -16'sd2);
    send_tick();
    send_tick();
    send_item(MODE_START, 16'sd4096);
    send_item(MODE_START, -16'sd4096);
    send_tick();
    wait_quiet();
  endtask

  // gains sitting above a lowered target step down toward it
  task automatic test_gain_above_full();
    set_targets(FULL_TOP, FULL_TOP, FULL_TOP, FULL_TOP);
    send_item(MODE_START, -16'sd1);
    send_tick();
    wait_quiet();
    set_targets(19'd0, 19'h2A5A5, FULL_TOP, 19'h15A5A);
    send_item(MODE_START, -16'sd6);
    repeat (7) send_tick();
    send_item(MODE_START, -16'sd5);
    repeat (3) send_tick();
    wait_quiet();
  endtask

  // whole fades with random counts, plus idle ticks, cut-short fades and noise
  task automatic run_random_fades(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned ticks;
    int          mag;
    logic signed [15:0] frames;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_item(logic'($urandom_range(1)), 16'($urandom));
        sent++;
      end else begin
        if (pick < 62) begin
          mag    = $urandom_range(1, 24);
          frames = $urandom_range(1) ? -16'(mag) : 16'(mag);
          ticks  = mag + $urandom_range(0, 3);
        end else if (pick < 70) begin
          frames = 16'sd0;
          ticks  = $urandom_range(1, 4);
        end else if (pick < 85) begin
          frames = 16'($urandom);
          ticks  = $urandom_range(0, 30);
        end else begin
          mag    = $urandom_range(25, 4095);
          frames = $urandom_range(1) ? -16'(mag) : 16'(mag);
          ticks  = $urandom_range(1, 30);
        end
        if ($urandom_range(9) == 0) ticks = $urandom_range(0, ticks);
        send_item(MODE_START, frames);
        repeat (ticks) send_tick();
        sent += 1 + ticks;
      end
    end
  endtask

  function automatic full_t rand_target();
    return full_t'($urandom_range(FULL_TOP));
  endfunction

  // random traffic under each idling pattern, with new targets per phase
  task automatic test_idle_phases();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    set_targets(rand_target(), rand_target(), rand_target(), rand_target());
    run_random_fades(PHASE_ITEMS);
    wait_quiet();

    send_gap_pct   = 57;
    recv_stall_pct = 0;
    set_targets(FULL_TOP, FULL_TOP, FULL_TOP, FULL_TOP);
    run_random_fades(PHASE_ITEMS);
    wait_quiet();

    send_gap_pct   = 0;
    recv_stall_pct = 57;
    set_targets(19'd0, 19'd0, 19'd0, 19'd0);
    run_random_fades(PHASE_ITEMS);
    wait_quiet();

    send_gap_pct   = 22;
    recv_stall_pct = 22;
    set_targets(FULL_TOP, rand_target(), 19'd0, rand_target());
    run_random_fades(PHASE_ITEMS);
    wait_quiet();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ramps();
    test_gain_above_full();
    test_idle_phases();
    if (mismatch_count == 0 && expected_mix.size() == 0) begin
      $display("** four_channel_volume_fade: PASSED **");
    end else begin
      $display("** four_channel_volume_fade: FAILED **");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #50_000_000;
    $display("** four_channel_volume_fade: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
src/fvf_pkg.sv
src/fvf_div.sv
src/four_channel_volume_fade.sv
tb/tb_top.sv
